// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/obrq_pkg.sv
// ----------------------------------------------------------------------------
// obrq_pkg
// Operation codes and fixed field widths of the byte ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package obrq_pkg;

  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;
  localparam int OP_W   = 3;

  // Operation codes carried by each input item
  localparam logic [OP_W-1:0] OP_ENQ  = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 3'd1;
  localparam logic [OP_W-1:0] OP_REP  = 3'd2;
  localparam logic [OP_W-1:0] OP_SRCH = 3'd3;
  localparam logic [OP_W-1:0] OP_CLR  = 3'd4;

endpackage

`default_nettype wire

// File: rtl/obrq_ptr.sv
// ----------------------------------------------------------------------------
// obrq_ptr
// Ring pointer arithmetic: wrapped advance of head, tail and scan index,
// and the element count derived from the pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module obrq_ptr #(
  parameter int DEPTH = 64
) (
  input  wire logic [$clog2(DEPTH)-1:0]    head,
  input  wire logic [$clog2(DEPTH)-1:0]    tail,
  input  wire logic [$clog2(DEPTH)-1:0]    sidx,
  input  wire logic                        has_room,
  input  wire logic [obrq_pkg::LEN_W-1:0]  qlen,
  output logic      [$clog2(DEPTH)-1:0]    head_adv,
  output logic      [$clog2(DEPTH)-1:0]    tail_adv,
  output logic      [$clog2(DEPTH)-1:0]    sidx_adv,
  output logic      [obrq_pkg::LEN_W-1:0]  count
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = obrq_pkg::LEN_W;
  localparam int XW = (AW + 1 > LW) ? AW + 1 : LW;

  logic [XW-1:0] h_x;
  logic [XW-1:0] t_x;
  logic [XW-1:0] q_x;
  logic [XW-1:0] cnt_x;

  // Step an index by one, wrapping at the configured length
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx,
                                        input logic [XW-1:0] len);
    logic [XW-1:0] n;
    n = XW'(idx) + XW'(1);
    return (n >= len) ? '0 : n[AW-1:0];
  endfunction

  assign h_x = XW'(head);
  assign t_x = XW'(tail);
  assign q_x = XW'(qlen);

  assign head_adv = adv(head, q_x);
  assign tail_adv = adv(tail, q_x);
  assign sidx_adv = adv(sidx, q_x);

  // Count valid elements; a full ring is marked by has_room low
  always_comb begin
    if (!has_room) begin
      cnt_x = q_x;
    end else if (head == tail) begin
      cnt_x = '0;
    end else if (t_x >= h_x) begin
      cnt_x = t_x - h_x;
    end else begin
      cnt_x = t_x + q_x - h_x;
    end
  end

  assign count = cnt_x[LW-1:0];

endmodule

`default_nettype wire

// File: rtl/overwriting_byte_ring_queue.sv
// ----------------------------------------------------------------------------
// overwriting_byte_ring_queue
// Byte ring queue with a configurable length. Enqueue into a full queue
// overwrites the oldest byte. Replace and search walk the slot memory one slot
// per cycle through a single compare unit; clear walks it writing zeros.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  in       | in_valid/in_stall  | operation, data_byte, replacement_byte
//  out      | out_valid/out_stall| read_byte, hit, element_count, is_full,
//           |                    | is_empty
//  cfg      | cfg_we             | cfg_data (queue length)
//
//  One item is handled at a time; replace walks all queue_length slots,
//  search walks element_count slots from the head, clear zeroes
//  queue_length slots, and scans read one slot per cycle. After reset a
//  clearing pass zeroes all DEPTH slots before the first item is taken. A
//  stalled result holds the sequencer in its final step; the next item is
//  taken once that result has left the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_byte_ring_queue #(
  parameter int DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [obrq_pkg::LEN_W-1:0]    cfg_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [obrq_pkg::OP_W-1:0]     operation,
  input  wire logic [obrq_pkg::BYTE_W-1:0]   data_byte,
  input  wire logic [obrq_pkg::BYTE_W-1:0]   replacement_byte,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [obrq_pkg::BYTE_W-1:0]   read_byte,
  output logic                               hit,
  output logic      [obrq_pkg::LEN_W-1:0]    element_count,
  output logic                               is_full,
  output logic                               is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = obrq_pkg::LEN_W;
  localparam int BW = obrq_pkg::BYTE_W;
  localparam int XW = (AW + 1 > LW) ? AW + 1 : LW;
  localparam logic [LW-1:0] QLEN_RST = LW'((DEPTH < 64) ? DEPTH : 64);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ENQ,
    S_DEQ,
    S_DEQ_RD,
    S_SCAN,
    S_CLR,
    S_DONE
  } state_t;

  state_t state;

  // Queue state
  logic [AW-1:0]   head;
  logic [AW-1:0]   tail;
  logic            has_room;
  logic [LW-1:0]   qlen;

  // Latched item
  logic [obrq_pkg::OP_W-1:0] op_q;
  logic [BW-1:0]   key_q;
  logic [BW-1:0]   repl_q;
  logic [BW-1:0]   rd_q;
  logic            hit_q;

  // Scan sequencer
  logic [AW-1:0]   sidx;
  logic [CW-1:0]   rem;
  logic            cmp_vld;
  logic [AW-1:0]   cmp_addr;

  // Slot memory
  logic [BW-1:0]   mem [DEPTH];
  logic [BW-1:0]   rdata;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [BW-1:0]   wdata;
  logic [AW-1:0]   raddr;

  logic [AW-1:0]   head_adv;
  logic [AW-1:0]   tail_adv;
  logic [AW-1:0]   sidx_adv;
  logic [LW-1:0]   count;
  logic            match;
  logic            accept;
  logic            out_free;
  logic [LW-1:0]   cfg_len;

  obrq_ptr #(
    .DEPTH(DEPTH)
  ) u_ptr (
    .head     (head),
    .tail     (tail),
    .sidx     (sidx),
    .has_room (has_room),
    .qlen     (qlen),
    .head_adv (head_adv),
    .tail_adv (tail_adv),
    .sidx_adv (sidx_adv),
    .count    (count)
  );

  // Shared byte compare
  assign match = (rdata == key_q);

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Clamp the written length into 1..DEPTH
  always_comb begin
    if (cfg_data == '0) begin
      cfg_len = LW'(1);
    end else if (XW'(cfg_data) > XW'(DEPTH)) begin
      cfg_len = LW'(DEPTH);
    end else begin
      cfg_len = cfg_data;
    end
  end

  // Steer the memory ports
  always_comb begin
    we    = 1'b0;
    waddr = sidx;
    wdata = '0;
    raddr = sidx;
    unique case (state) inside
      S_INIT, S_CLR: begin
        we = 1'b1;
      end
      S_ENQ: begin
        we    = 1'b1;
        waddr = tail;
        wdata = key_q;
      end
      S_DEQ: begin
        raddr = head;
      end
      S_SCAN: begin
        if (cmp_vld && match && (op_q == obrq_pkg::OP_REP)) begin
          we    = 1'b1;
          waddr = cmp_addr;
          wdata = repl_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Sequencer, queue state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      head      <= '0;
      tail      <= '0;
      has_room  <= 1'b1;
      qlen      <= QLEN_RST;
      sidx      <= '0;
      rem       <= CW'(DEPTH);
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken result; the final step reloads the register instead
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_INIT: begin
          sidx <= sidx + AW'(1);
          rem  <= rem - CW'(1);
          if (rem == CW'(1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            op_q    <= operation;
            key_q   <= data_byte;
            repl_q  <= replacement_byte;
            rd_q    <= '0;
            hit_q   <= 1'b0;
            cmp_vld <= 1'b0;
            unique case (operation)
              obrq_pkg::OP_ENQ: begin
                state <= S_ENQ;
              end
              obrq_pkg::OP_DEQ: begin
                state <= S_DEQ;
              end
              obrq_pkg::OP_REP: begin
                sidx  <= '0;
                rem   <= CW'(qlen);
                state <= S_SCAN;
              end
              obrq_pkg::OP_SRCH: begin
                sidx  <= head;
                rem   <= CW'(count);
                state <= S_SCAN;
              end
              obrq_pkg::OP_CLR: begin
                sidx  <= '0;
                rem   <= CW'(qlen);
                state <= S_CLR;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
          // new length empties the queue, slot bytes are kept
          if (cfg_we) begin
            qlen     <= cfg_len;
            head     <= '0;
            tail     <= '0;
            has_room <= 1'b1;
          end
        end

        S_ENQ: begin
          if (has_room) begin
            tail <= tail_adv;
            if (head == tail_adv) begin
              has_room <= 1'b0;
            end
          end else begin
            head <= head_adv;
            tail <= tail_adv;
          end
          state <= S_DONE;
        end

        S_DEQ: begin
          state <= (count != '0) ? S_DEQ_RD : S_DONE;
        end

        S_DEQ_RD: begin
          rd_q     <= rdata;
          head     <= head_adv;
          has_room <= 1'b1;
          state    <= S_DONE;
        end

        S_SCAN: begin
          // issue one read a cycle, compare it the cycle after
          if (rem != '0) begin
            cmp_vld  <= 1'b1;
            cmp_addr <= sidx;
            sidx     <= sidx_adv;
            rem      <= rem - CW'(1);
          end else begin
            cmp_vld <= 1'b0;
          end
          if (cmp_vld && match) begin
            hit_q <= 1'b1;
          end
          if ((rem == '0) && !cmp_vld) begin
            state <= S_DONE;
          end
        end

        S_CLR: begin
          sidx <= sidx + AW'(1);
          rem  <= rem - CW'(1);
          if (rem == CW'(1)) begin
            head     <= '0;
            tail     <= '0;
            has_room <= 1'b1;
            state    <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            read_byte     <= rd_q;
            hit           <= hit_q;
            element_count <= count;
            is_full       <= (count == qlen);
            is_empty      <= (count == '0);
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/obrq_checker.sv
// ----------------------------------------------------------------------------
// obrq_checker
// Port-level checks of the byte ring queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module obrq_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [obrq_pkg::BYTE_W-1:0]   read_byte,
  input wire logic                          hit,
  input wire logic [obrq_pkg::LEN_W-1:0]    element_count,
  input wire logic                          is_full,
  input wire logic                          is_empty
);

  logic [obrq_pkg::BYTE_W+obrq_pkg::LEN_W+2:0] out_word;

  // Gather the result fields for the hold check
  assign out_word = {read_byte, hit, element_count, is_full, is_empty};

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))

  // One item at a time: busy right after an acceptance
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // Empty flag agrees with the count
  `ASSERT_IMPLY(a_empty_count, clk, rst, out_valid, is_empty == (element_count == '0))

  // Length is at least one, so never full and empty together
  `ASSERT_IMPLY(a_full_empty, clk, rst, out_valid, !(is_full && is_empty))

  // A hit comes from replace or search, which return no byte
  `ASSERT_IMPLY(a_hit_no_byte, clk, rst, out_valid && hit, read_byte == '0)

endmodule

bind overwriting_byte_ring_queue obrq_checker u_obrq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .read_byte     (read_byte),
  .hit           (hit),
  .element_count (element_count),
  .is_full       (is_full),
  .is_empty      (is_empty)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the overwriting byte ring queue. A queue of
// operations feeds a clocked driver, and an in-bench ring model predicts every
// result. A clocked monitor compares each result field by field. The run
// covers a directed opening and random bursts under several queue lengths,
// with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH          = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 150;
  localparam int NUM_PHASES     = 8;
  // codes with no operation behind them
  localparam logic [obrq_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [obrq_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [obrq_pkg::OP_W-1:0]   op;
    logic [obrq_pkg::BYTE_W-1:0] data;
    logic [obrq_pkg::BYTE_W-1:0] repl;
  } queue_op_t;

  typedef struct packed {
    logic [obrq_pkg::BYTE_W-1:0] rd;
    logic                        hit;
    logic [obrq_pkg::LEN_W-1:0]  count;
    logic                        full;
    logic                        empty;
  } queue_status_t;

  logic                          clk;
  logic                          rst              = 1'b1;
  logic                          cfg_we           = 1'b0;
  logic [obrq_pkg::LEN_W-1:0]    cfg_data         = '0;
  logic                          in_valid         = 1'b0;
  logic                          in_stall;
  logic [obrq_pkg::OP_W-1:0]     operation        = obrq_pkg::OP_ENQ;
  logic [obrq_pkg::BYTE_W-1:0]   data_byte        = '0;
  logic [obrq_pkg::BYTE_W-1:0]   replacement_byte = '0;
  logic                          out_valid;
  logic                          out_stall        = 1'b0;
  logic [obrq_pkg::BYTE_W-1:0]   read_byte;
  logic                          hit;
  logic [obrq_pkg::LEN_W-1:0]    element_count;
  logic                          is_full;
  logic                          is_empty;

  // ring model state
  logic [obrq_pkg::BYTE_W-1:0]   ring_slots [DEPTH];
  int                  ring_head;
  int                  ring_tail;
  int                  ring_len;
  bit                  ring_room;

  queue_op_t           pending_items [$];
  queue_status_t       expected_results [$];
  queue_op_t           driven_item;
  queue_status_t       seen_status;
  queue_status_t       want_status;

  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  int                  items_queued  = 0;
  int                  items_taken   = 0;
  int                  results_seen  = 0;
  int                  hit_count     = 0;
  int                  error_count   = 0;
  int                  length_writes = 0;
  int                  idle_cycles   = 0;
  int                  phase_length [NUM_PHASES];

  overwriting_byte_ring_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .data_byte        (data_byte),
    .replacement_byte (replacement_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .read_byte        (read_byte),
    .hit              (hit),
    .element_count    (element_count),
    .is_full          (is_full),
    .is_empty         (is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Ring model
  // ---------------------------------------------------------------------------
  function automatic int ring_next(int idx);
    return (idx + 1 >= ring_len) ? 0 : idx + 1;
  endfunction

  function automatic int ring_count();
    if (!ring_room) return ring_len;
    if (ring_head == ring_tail) return 0;
    if (ring_tail > ring_head) return ring_tail - ring_head;
    return ring_tail + ring_len - ring_head;
  endfunction

  // Clamp the new length and empty the queue; slot bytes stay.
  function automatic void set_ring_length(logic [obrq_pkg::LEN_W-1:0] value);
    int v;
    v = value;
    if (v < 1) v = 1;
    if (v > DEPTH) v = DEPTH;
    ring_len  = v;
    ring_head = 0;
    ring_tail = 0;
    ring_room = 1'b1;
  endfunction

  function automatic queue_status_t apply_queue_op(queue_op_t it);
    queue_status_t res;
    int            n;
    int            idx;
    int            i;
    res = '0;
    case (it.op)
      obrq_pkg::OP_ENQ: begin
        // a full queue drops its oldest byte
        ring_slots[ring_tail] = it.data;
        if (ring_room) begin
          ring_tail = ring_next(ring_tail);
          if (ring_head == ring_tail) ring_room = 1'b0;
        end else begin
          ring_head = ring_next(ring_head);
          ring_tail = ring_next(ring_tail);
        end
      end
      obrq_pkg::OP_DEQ: begin
        if (ring_count() > 0) begin
          res.rd    = ring_slots[ring_head];
          ring_head = ring_next(ring_head);
          ring_room = 1'b1;
        end
      end
      obrq_pkg::OP_REP: begin
        // stale slots inside the length are rewritten too
        for (i = 0; i < ring_len; i++) begin
          if (ring_slots[i] == it.data) begin
            ring_slots[i] = it.repl;
            res.hit       = 1'b1;
          end
        end
      end
      obrq_pkg::OP_SRCH: begin
        // walk valid elements only, wrapping at the length
        n   = ring_count();
        idx = ring_head;
        for (i = 0; i < n && !res.hit; i++) begin
          if (ring_slots[idx] == it.data) res.hit = 1'b1;
          idx = ring_next(idx);
        end
      end
      obrq_pkg::OP_CLR: begin
        for (i = 0; i < ring_len; i++) ring_slots[i] = '0;
        ring_head = 0;
        ring_tail = 0;
        ring_room = 1'b1;
      end
      default: ;
    endcase
    n         = ring_count();
    res.count = obrq_pkg::LEN_W'(n);
    res.full  = (n == ring_len);
    res.empty = (n == 0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: predict on acceptance, then present the next item or idle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      operation        <= obrq_pkg::OP_ENQ;
      data_byte        <= '0;
      replacement_byte <= '0;
      for (int i = 0; i < DEPTH; i++) ring_slots[i] = '0;
      ring_len  = DEPTH;
      ring_head = 0;
      ring_tail = 0;
      ring_room = 1'b1;
    end else begin
      if (cfg_we) set_ring_length(cfg_data);
      if (in_valid && !in_stall) begin
        expected_results.push_back(
          apply_queue_op('{operation, data_byte, replacement_byte}));
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_item       = pending_items.pop_front();
          in_valid         <= 1'b1;
          operation        <= driven_item.op;
          data_byte        <= driven_item.data;
          replacement_byte <= driven_item.repl;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_status = '{read_byte, hit, element_count, is_full, is_empty};
        results_seen++;
        if (seen_status.hit) hit_count++;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: result with nothing expected: %s", $realtime,
                     $sformatf("rd=%02h hit=%0d cnt=%0d full=%0d empty=%0d",
                               read_byte, hit, element_count, is_full, is_empty));
        end else begin
          want_status = expected_results.pop_front();
          if (seen_status.rd !== want_status.rd || seen_status.hit !== want_status.hit ||
              seen_status.count !== want_status.count ||
              seen_status.full !== want_status.full ||
              seen_status.empty !== want_status.empty) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: mismatch exp rd=%02h hit=%0d cnt=%0d full=%0d empty=%0d",
                       $realtime, want_status.rd, want_status.hit, want_status.count,
                       want_status.full, want_status.empty);
              $display("%0t:          got rd=%02h hit=%0d cnt=%0d full=%0d empty=%0d",
                       $realtime, seen_status.rd, seen_status.hit, seen_status.count,
                       seen_status.full, seen_status.empty);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: stop when no handshake of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("[overwriting_byte_ring_queue] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic [obrq_pkg::OP_W-1:0] op,
                            logic [obrq_pkg::BYTE_W-1:0] d,
                            logic [obrq_pkg::BYTE_W-1:0] r);
    pending_items.push_back('{op, d, r});
    items_queued++;
  endtask

  // Hold until every item is taken and every result has come back.
  task automatic wait_drained();
    while (items_taken != items_queued || expected_results.size() != 0) @(posedge clk);
  endtask

  // Write the length while idle, after letting the sequencer settle.
  task automatic write_length(logic [obrq_pkg::LEN_W-1:0] value);
    repeat (4) @(posedge clk);
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    length_writes++;
  endtask

  // Small values nearly half the time so searches and replaces hit.
  function automatic logic [obrq_pkg::BYTE_W-1:0] pick_byte();
    if ($urandom_range(99) < 45) return obrq_pkg::BYTE_W'($urandom_range(7));
    return obrq_pkg::BYTE_W'($urandom_range(255));
  endfunction

  // Bursts that fill, drain or mix, with some scans, clears and unused codes.
  task automatic queue_random_items(int count);
    int                         done;
    int                         burst;
    int                         mode;
    int                         r;
    logic [obrq_pkg::OP_W-1:0]  op;
    done = 0;
    while (done < count) begin
      burst = $urandom_range(4, 24);
      mode  = $urandom_range(2);
      for (int k = 0; k < burst && done < count; k++) begin
        r = $urandom_range(99);
        case (mode)
          0: op = (r < 75) ? obrq_pkg::OP_ENQ : (r < 85) ? obrq_pkg::OP_DEQ :
                  (r < 92) ? obrq_pkg::OP_SRCH : (r < 96) ? obrq_pkg::OP_REP :
                  obrq_pkg::OP_CLR;
          1: op = (r < 70) ? obrq_pkg::OP_DEQ : (r < 85) ? obrq_pkg::OP_ENQ :
                  (r < 93) ? obrq_pkg::OP_SRCH : (r < 97) ? obrq_pkg::OP_REP :
                  obrq_pkg::OP_CLR;
          default: op = (r < 40) ? obrq_pkg::OP_ENQ : (r < 70) ? obrq_pkg::OP_DEQ :
                        (r < 82) ? obrq_pkg::OP_SRCH : (r < 90) ? obrq_pkg::OP_REP :
                        (r < 95) ? obrq_pkg::OP_CLR : OP_UNUSED_LO;
        endcase
        if (op == obrq_pkg::OP_CLR && $urandom_range(1)) op = OP_UNUSED_LO;
        if (op == OP_UNUSED_LO)
          op = obrq_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        queue_item(op, pick_byte(), obrq_pkg::BYTE_W'($urandom_range(255)));
        done++;
      end
    end
  endtask

  initial begin
    phase_length = '{127, 0, 5, 64, 2, 17, 1, 40};
    phase_length[7] = $urandom_range(3, 63);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // hold off while the slot memory is cleared after reset
    repeat (DEPTH + 8) @(posedge clk);

    // Directed: three-slot ring through empty, full, overwrite, wrap and clear
    write_length(obrq_pkg::LEN_W'(3));
    queue_item(obrq_pkg::OP_DEQ,  8'h00, 8'h00);   // dequeue of empty
    queue_item(obrq_pkg::OP_SRCH, 8'h00, 8'h00);   // zero slots are not elements
    queue_item(obrq_pkg::OP_ENQ,  8'h00, 8'hFF);
    queue_item(obrq_pkg::OP_ENQ,  8'hFF, 8'h00);
    queue_item(obrq_pkg::OP_ENQ,  8'h80, 8'h00);   // now full
    queue_item(obrq_pkg::OP_ENQ,  8'h01, 8'h00);   // overwrite the oldest
    queue_item(obrq_pkg::OP_SRCH, 8'h00, 8'h00);   // overwritten byte is gone
    queue_item(obrq_pkg::OP_SRCH, 8'h01, 8'h00);   // found past the wrap
    queue_item(obrq_pkg::OP_DEQ,  8'h00, 8'h00);
    queue_item(obrq_pkg::OP_DEQ,  8'h00, 8'h00);
    queue_item(obrq_pkg::OP_REP,  8'hFF, 8'h55);   // matches a stale slot
    queue_item(obrq_pkg::OP_SRCH, 8'h55, 8'h00);   // stale slot is not searched
    queue_item(obrq_pkg::OP_DEQ,  8'h00, 8'h00);
    queue_item(obrq_pkg::OP_DEQ,  8'h00, 8'h00);   // empty again
    queue_item(obrq_pkg::OP_REP,  8'h12, 8'hAA);   // no match
    queue_item(obrq_pkg::OP_ENQ,  8'hAA, 8'hFF);
    queue_item(obrq_pkg::OP_CLR,  8'hFF, 8'hFF);
    for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
      queue_item(obrq_pkg::OP_W'(c), 8'hFF, 8'hFF);
    queue_item(obrq_pkg::OP_REP,  8'h00, 8'hFF);   // every cleared slot matches
    queue_item(obrq_pkg::OP_ENQ,  8'h7F, 8'h80);
    queue_item(obrq_pkg::OP_SRCH, 8'h7F, 8'h00);
    queue_item(obrq_pkg::OP_DEQ,  8'h00, 8'h00);
    wait_drained();

    // Random phases: step through lengths and idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_length(obrq_pkg::LEN_W'(phase_length[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      queue_random_items(PHASE_ITEMS);
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (10) @(posedge clk);
    $display("Ran %0d operations over %0d length settings;", items_taken, length_writes);
    $display("%0d results checked, %0d hits, %0d mismatches",
             results_seen, hit_count, error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[overwriting_byte_ring_queue] OK");
    end else begin
      $display("[overwriting_byte_ring_queue] ERROR");
    end
    $finish;
  end

endmodule

// File: overwriting_byte_ring_queue.f
+incdir+rtl
rtl/obrq_pkg.sv
rtl/obrq_ptr.sv
rtl/overwriting_byte_ring_queue.sv
rtl/obrq_checker.sv
tb/tb.sv
